@@ rtl/core/ptrt_pkg.sv @@
// Shared types and constants for the periodic task release timer.
package ptrt_pkg;

	localparam int MAX_EVENTS = 16;
	localparam int EVT_CNT_W = $clog2(MAX_EVENTS + 1);

	localparam logic EVT_RELEASE = 1'b0;
	localparam logic EVT_MISS = 1'b1;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_LOAD   = 2'd1,
		FUNC_START  = 2'd2,
		FUNC_FINISH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [3:0]  slot;
		logic        is_periodic;
		logic [15:0] period_value;
		logic [15:0] deadline_value;
		logic [15:0] initial_count;
	} in_item_t;

	typedef struct packed {
		logic       event_kind;
		logic [3:0] event_slot;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic hit;
		logic kind;
		logic wr_en;
	} slot_verdict_t;

endpackage

@@ rtl/core/ptrt_slot_eval.sv @@
// Per-slot tick decision: deadline miss, release or count advance.
module ptrt_slot_eval import ptrt_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  periodic,
	input  logic                  running,
	input  logic [COUNT_BITS-1:0] count,
	input  logic [COUNT_BITS-1:0] period,
	input  logic [COUNT_BITS-1:0] deadline,
	output slot_verdict_t         verdict,
	output logic [COUNT_BITS-1:0] next_count
);

	always_comb begin
		verdict = '0;
		next_count = count + COUNT_BITS'(1);
		if (periodic) begin
			if (running && (count == deadline)) begin
				verdict.hit = 1'b1;
				verdict.kind = EVT_MISS;
				next_count = count;
			end else if (count == period) begin
				verdict.hit = 1'b1;
				verdict.kind = EVT_RELEASE;
				verdict.wr_en = 1'b1;
				next_count = COUNT_BITS'(1);
			end else begin
				verdict.wr_en = 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/periodic_task_release_timer.sv @@
// Top level of the periodic task release timer: slot memory, tick walker and output register.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data (in_item_t)
// out      output     out_valid / out_ready  out_data (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_data (enable bit)
//
// A load, start or finish item takes effect in the cycle that accepts it; in_ready is high
// whenever no tick is in work. A tick accepted while enabled holds in_ready low through the
// walk and the flush, stalls on the output included: the walk reads one slot entry a cycle,
// when no event is stalled, from the single-port-read slot memory and writes the new count back.
// Each event is held in a pending register so the final one can carry last; the walk pauses
// when a new event finds one pending and the output register full. The memory needs no
// clearing after reset; the periodic and running flags are flip-flops cleared by arst_n.
module periodic_task_release_timer import ptrt_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int ENT_W = 3 * COUNT_BITS;

	state_t state_q, state_d;

	logic                  enable_q;
	logic [NUM_SLOTS-1:0]  periodic_q;
	logic [NUM_SLOTS-1:0]  running_q;
	logic [ENT_W-1:0]      mem [NUM_SLOTS];
	logic [ENT_W-1:0]      rd_data_s1;
	logic                  v_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [EVT_CNT_W-1:0]  n_q;
	logic                  pend_v_q;
	logic                  pend_kind_q;
	logic [3:0]            pend_slot_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  mem_re, mem_we;
	logic [IDX_W-1:0]      mem_ra, mem_wa;
	logic [ENT_W-1:0]      mem_wd;
	logic                  advance, push, take, out_free, walk_end, start_tick;
	out_item_t             push_item;
	slot_verdict_t         verdict;
	logic [COUNT_BITS-1:0] next_count;
	logic [COUNT_BITS-1:0] rd_period, rd_deadline, rd_count;
	logic [IDX_W-1:0]      slot_idx;
	logic                  slot_ok, in_acc;

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign in_acc = in_valid && in_ready;
	assign slot_idx = IDX_W'(in_data.slot);
	assign slot_ok = (9'(in_data.slot) < 9'(NUM_SLOTS));
	assign start_tick = in_acc && (in_data.func == FUNC_TICK) && enable_q;

	assign rd_period = rd_data_s1[ENT_W-1 -: COUNT_BITS];
	assign rd_deadline = rd_data_s1[2*COUNT_BITS-1 -: COUNT_BITS];
	assign rd_count = rd_data_s1[COUNT_BITS-1:0];

	ptrt_slot_eval #(
		.COUNT_BITS(COUNT_BITS)
	) u_eval (
		.periodic  (v_s1 && periodic_q[idx_s1]),
		.running   (running_q[idx_s1]),
		.count     (rd_count),
		.period    (rd_period),
		.deadline  (rd_deadline),
		.verdict   (verdict),
		.next_count(next_count)
	);

	assign out_free = !out_valid_q || out_ready;
	assign take = v_s1 && verdict.hit && (n_q < EVT_CNT_W'(MAX_EVENTS));
	assign walk_end = (rd_idx_q == CNT_W'(NUM_SLOTS));

	always_comb begin
		state_d = state_q;
		advance = 1'b0;
		push = 1'b0;
		push_item.event_kind = pend_kind_q;
		push_item.event_slot = pend_slot_q;
		push_item.last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start_tick) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				advance = !(take && pend_v_q && !out_free);
				push = take && pend_v_q && out_free;
				if (advance && walk_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				push_item.last = 1'b1;
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_re = (state_q == ST_WALK) && advance && !walk_end;
		mem_ra = IDX_W'(rd_idx_q);
		if (state_q == ST_WALK) begin
			mem_we = advance && v_s1 && verdict.wr_en;
			mem_wa = idx_s1;
			mem_wd = {rd_period, rd_deadline, next_count};
		end else begin
			mem_we = in_acc && (in_data.func == FUNC_LOAD) && slot_ok;
			mem_wa = slot_idx;
			mem_wd = {COUNT_BITS'(in_data.period_value), COUNT_BITS'(in_data.deadline_value),
				COUNT_BITS'(in_data.initial_count)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			periodic_q <= '0;
			running_q <= '0;
			v_s1 <= 1'b0;
			rd_idx_q <= '0;
			n_q <= '0;
			pend_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enable_q <= cfg_data;
			end
			if (in_acc && slot_ok) begin
				case (in_data.func)
					FUNC_LOAD: periodic_q[slot_idx] <= in_data.is_periodic;
					FUNC_START: running_q[slot_idx] <= 1'b1;
					FUNC_FINISH: running_q[slot_idx] <= 1'b0;
					default: ;
				endcase
			end
			if (start_tick) begin
				v_s1 <= 1'b0;
				rd_idx_q <= '0;
				n_q <= '0;
				pend_v_q <= 1'b0;
			end else if ((state_q == ST_WALK) && advance) begin
				v_s1 <= mem_re;
				if (mem_re) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (take) begin
					n_q <= n_q + EVT_CNT_W'(1);
					pend_v_q <= 1'b1;
				end
			end else if ((state_q == ST_FLUSH) && (state_d == ST_IDLE)) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			idx_s1 <= mem_ra;
		end
		if ((state_q == ST_WALK) && advance && take) begin
			pend_kind_q <= verdict.kind;
			pend_slot_q <= 4'(idx_s1);
		end
		if (push) begin
			out_q <= push_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !v_s1)
		else $error("Slot stage holds an entry while no tick is in work.");

	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= EVT_CNT_W'(MAX_EVENTS))
		else $error("Event count exceeds the per-tick limit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wa != mem_ra))
		else $error("Slot memory read and write hit the same entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (walk_end && !v_s1))
		else $error("Flush entered before the walk finished.");

endmodule
